>>> src/rbks_pkg.sv
// Shared types and constants of the ring buffer keyword scanner.
package rbks_pkg;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_ARM   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_FIRST_KW   = 3'd0,
    CFG_FIRST_LEN  = 3'd1,
    CFG_SECOND_KW  = 3'd2,
    CFG_SECOND_LEN = 3'd3,
    CFG_MODE       = 3'd4,
    CFG_LINE_END   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KW_NONE   = 2'd0,
    KW_FIRST  = 2'd1,
    KW_SECOND = 2'd2
  } kw_sel_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KW_W       = 64;
  localparam int unsigned KW_LEN_W   = 4;
  localparam int unsigned MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_SKIP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TWO  = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Ring control for one beat, already qualified by the pipeline advance.
  typedef struct packed {
    logic advance;
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

  typedef struct packed {
    logic rd_valid;
    logic not_empty_nxt;
  } ring_stat_t;

endpackage

>>> src/rbks_if.sv
// Valid/ready channel interfaces for requests and results.
interface rbks_in_if;
  logic                valid;
  logic                ready;
  rbks_pkg::req_t      req_type;
  logic [7:0]          in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface rbks_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       ring_not_empty;
  logic       search_armed;
  logic       search_done;
  logic [1:0] matched_keyword;

  modport source (output valid, output out_byte, output out_valid, output ring_not_empty,
                  output search_armed, output search_done, output matched_keyword,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input ring_not_empty,
                  input search_armed, input search_done, input matched_keyword,
                  output ready);
endinterface

>>> src/rbks_match.sv
// Naive keyword matcher: match position register and the per-byte compare.
module rbks_match #(
  parameter int unsigned MAX_KEYWORD_CHARS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rbks_pkg::KW_W-1:0]     kw,
  input  logic [rbks_pkg::KW_LEN_W-1:0] kw_len,
  input  logic [7:0]                    ch,
  input  logic                          step,
  input  logic                          restart,
  output logic                          hit
);
  import rbks_pkg::*;

  localparam int unsigned MPW = $clog2(MAX_KEYWORD_CHARS + 1);

  logic [MPW-1:0] pos_r;
  logic [MPW-1:0] pos_nxt;
  logic [MPW-1:0] len_c;
  logic [MPW-1:0] p0;
  logic [MPW-1:0] p1;
  logic [MPW-1:0] p2;

  function automatic logic [7:0] kw_char(input logic [KW_W-1:0] w, input logic [MPW-1:0] p);
    logic [2:0] idx;
    idx = 3'(p);
    return w[{idx, 3'b000} +: 8];
  endfunction

  always_comb begin
    if (kw_len > KW_LEN_W'(MAX_KEYWORD_CHARS)) begin
      len_c = MPW'(MAX_KEYWORD_CHARS);
    end else begin
      len_c = MPW'(kw_len);
    end
    p0 = (pos_r >= len_c) ? '0 : pos_r;
    p1 = (kw_char(kw, p0) != ch) ? '0 : p0;
    p2 = (kw_char(kw, p1) == ch) ? p1 + MPW'(1) : p1;
    // An empty keyword completes at once and leaves the position alone.
    hit     = (len_c == '0) || (p2 >= len_c);
    pos_nxt = (len_c == '0) ? pos_r : p2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (restart) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> src/rbks_ring.sv
// Byte ring: storage, read and write pointers, fill count and registered read data.
module rbks_ring #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rbks_pkg::ring_ctrl_t ctrl,
  input  logic [7:0]           wr_data,
  output logic [7:0]           rd_data,
  output rbks_pkg::ring_stat_t stat
);
  import rbks_pkg::*;

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);

  logic [7:0]    mem [RING_DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [FW-1:0] fill_r;
  logic [7:0]    rd_data_r;
  logic          full;
  logic          has_data;
  logic          do_pop;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full     = (fill_r == FW'(RING_DEPTH));
  assign has_data = (fill_r != '0);
  assign do_pop   = ctrl.pop && has_data;

  always_comb begin
    stat.rd_valid = do_pop;
    if (ctrl.clear) begin
      stat.not_empty_nxt = 1'b0;
    end else if (ctrl.push) begin
      stat.not_empty_nxt = 1'b1;
    end else if (do_pop) begin
      stat.not_empty_nxt = (fill_r != FW'(1));
    end else begin
      stat.not_empty_nxt = has_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wp_r] <= wr_data;
    end
    if (ctrl.advance) begin
      rd_data_r <= do_pop ? mem[rp_r] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else if (ctrl.clear) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else if (ctrl.push) begin
      wp_r <= next_ptr(wp_r);
      // Full: overwrite the oldest byte and drag the read side along.
      if (full) begin
        rp_r <= next_ptr(rp_r);
      end else begin
        fill_r <= fill_r + FW'(1);
      end
    end else if (do_pop) begin
      rp_r   <= next_ptr(rp_r);
      fill_r <= fill_r - FW'(1);
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/ring_buffer_keyword_scanner.sv
// Top level of the ring buffer keyword scanner: pipeline, search control and configuration.
//
// Each request beat (byte, read, arm or clear) produces exactly one result beat. A beat is
// captured in an input register, evaluated by single-pass logic (keyword and CR LF compares,
// ring pointer update) and lands in the result register, so the block takes one beat per
// clock while results are taken. While a result waits on the output, one more beat is held in
// the input register and the input then stalls until the result is taken. The ring is a
// RING_DEPTH-byte memory with one write port and one registered read port; a read sees every
// byte stored by earlier beats. The ring needs no clearing after reset because reads are gated
// by the fill count. Bytes are stored and matched only while a search is armed. The user must
// write configuration through the cfg_ port only while idle; the block does not enforce this.
module ring_buffer_keyword_scanner #(
  parameter int unsigned RING_DEPTH        = 16,
  parameter int unsigned MAX_KEYWORD_CHARS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rbks_in_if.sink                         in_if,
  rbks_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [rbks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbks_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rbks_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_KEYWORD = 2'd1,
    PH_LINE    = 2'd2
  } phase_t;

  // Configuration registers
  logic [KW_W-1:0]     kw1_r;
  logic [KW_LEN_W-1:0] kw1_len_r;
  logic [KW_W-1:0]     kw2_r;
  logic [KW_LEN_W-1:0] kw2_len_r;
  logic [MODE_W-1:0]   mode_r;
  logic                line_end_r;

  // Input stage
  logic       s1_valid_r;
  req_t       s1_req_r;
  logic [7:0] s1_byte_r;

  // Search state and result register
  phase_t     phase_r;
  phase_t     phase_nxt;
  kw_sel_t    found_r;
  kw_sel_t    found_nxt;
  logic [1:0] line_pos_r;
  logic [1:0] line_pos_nxt;
  logic       out_valid_r;
  logic       rd_valid_r;
  logic       not_empty_r;
  logic       armed_r;
  logic       done_r;
  kw_sel_t    which_r;

  logic       fire;
  logic       is_byte;
  logic       skip;
  logic       two;
  logic       kw_step;
  logic       restart;
  logic       hit1;
  logic       hit2;
  kw_sel_t    hit;
  logic       done;
  kw_sel_t    which;
  logic [1:0] lp0;
  logic [1:0] lp1;
  logic [1:0] lp2;
  logic [7:0] crlf_ch0;
  logic [7:0] crlf_ch1;
  ring_ctrl_t ring_ctrl;
  ring_stat_t ring_stat;
  logic [7:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw1_r      <= '0;
      kw1_len_r  <= '0;
      kw2_r      <= '0;
      kw2_len_r  <= '0;
      mode_r     <= MODE_ONE;
      line_end_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_KW:   kw1_r      <= cfg_wdata[KW_W-1:0];
        CFG_FIRST_LEN:  kw1_len_r  <= cfg_wdata[KW_LEN_W-1:0];
        CFG_SECOND_KW:  kw2_r      <= cfg_wdata[KW_W-1:0];
        CFG_SECOND_LEN: kw2_len_r  <= cfg_wdata[KW_LEN_W-1:0];
        CFG_MODE:       mode_r     <= cfg_wdata[MODE_W-1:0];
        CFG_LINE_END:   line_end_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: the input stage advances whenever the result slot frees up.
  assign fire        = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_req_r  <= in_if.req_type;
      s1_byte_r <= in_if.in_byte;
    end
  end

  assign is_byte = (s1_req_r == REQ_BYTE);
  assign skip    = (mode_r == MODE_SKIP);
  assign two     = (mode_r >= MODE_TWO);
  assign kw_step = fire && is_byte && (phase_r == PH_KEYWORD);
  assign restart = fire && (s1_req_r == REQ_ARM);

  rbks_match #(.MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS)) u_match1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .kw      (kw1_r),
    .kw_len  (kw1_len_r),
    .ch      (s1_byte_r),
    .step    (kw_step),
    .restart (restart),
    .hit     (hit1)
  );

  // The second keyword is only stepped when the first did not complete.
  rbks_match #(.MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS)) u_match2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .kw      (kw2_r),
    .kw_len  (kw2_len_r),
    .ch      (s1_byte_r),
    .step    (kw_step && two && !hit1),
    .restart (restart),
    .hit     (hit2)
  );

  assign hit = hit1 ? KW_FIRST : ((two && hit2) ? KW_SECOND : KW_NONE);

  always_comb begin
    ring_ctrl.advance = fire;
    ring_ctrl.push    = fire && is_byte && (phase_r != PH_IDLE) && !skip;
    ring_ctrl.pop     = fire && (s1_req_r == REQ_READ);
    ring_ctrl.clear   = fire && (s1_req_r == REQ_CLEAR);
  end

  rbks_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ring_ctrl),
    .wr_data (s1_byte_r),
    .rd_data (rd_data),
    .stat    (ring_stat)
  );

  // CR LF tracker
  always_comb begin
    lp0      = (line_pos_r > 2'd1) ? 2'd0 : line_pos_r;
    crlf_ch0 = (lp0 == 2'd0) ? CHAR_CR : CHAR_LF;
    lp1      = (crlf_ch0 != s1_byte_r) ? 2'd0 : lp0;
    crlf_ch1 = (lp1 == 2'd0) ? CHAR_CR : CHAR_LF;
    lp2      = (crlf_ch1 == s1_byte_r) ? lp1 + 2'd1 : lp1;
  end

  always_comb begin
    phase_nxt    = phase_r;
    found_nxt    = found_r;
    line_pos_nxt = line_pos_r;
    done         = 1'b0;
    which        = KW_NONE;
    unique case (s1_req_r)
      REQ_BYTE: begin
        unique case (phase_r)
          PH_KEYWORD: begin
            if (hit != KW_NONE) begin
              found_nxt = hit;
              if (!skip && line_end_r) begin
                line_pos_nxt = 2'd0;
                phase_nxt    = PH_LINE;
              end else begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
                which     = hit;
              end
            end
          end
          PH_LINE: begin
            line_pos_nxt = lp2;
            if (lp2 >= 2'd2) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              which     = found_r;
            end
          end
          PH_IDLE: ;
          default: ;
        endcase
      end
      REQ_ARM: begin
        line_pos_nxt = 2'd0;
        found_nxt    = KW_NONE;
        phase_nxt    = PH_KEYWORD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      found_r     <= KW_NONE;
      line_pos_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        found_r     <= found_nxt;
        line_pos_r  <= line_pos_nxt;
        out_valid_r <= 1'b1;
        rd_valid_r  <= ring_stat.rd_valid;
        not_empty_r <= ring_stat.not_empty_nxt;
        armed_r     <= (phase_nxt != PH_IDLE);
        done_r      <= done;
        which_r     <= which;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.out_byte        = rd_data;
  assign out_if.out_valid       = rd_valid_r;
  assign out_if.ring_not_empty  = not_empty_r;
  assign out_if.search_armed    = armed_r;
  assign out_if.search_done     = done_r;
  assign out_if.matched_keyword = which_r;

endmodule

>>> src/rbks_checker.sv
// Port-level checks on the scanner's result channel, bound to the top level.
module rbks_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_v,
  input logic       out_rdy,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       ring_not_empty,
  input logic       search_armed,
  input logic       search_done,
  input logic [1:0] matched_keyword
);
  import rbks_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v && !out_rdy |=> out_v && $stable(out_byte) && $stable(out_valid) &&
      $stable(ring_not_empty) && $stable(search_done) && $stable(matched_keyword))
    else $error("result beat changed while stalled");

  // The completing byte ends the search.
  a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_v && search_done |-> !search_armed)
    else $error("search reported done but still armed");

  // A keyword is named exactly on the completing beat.
  a_done_names_kw: assert property (@(posedge clk) disable iff (!rst_n)
    out_v |-> (search_done == (matched_keyword != KW_NONE)))
    else $error("matched keyword out of step with search done");

  // No byte read means a zero data field.
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v && !out_valid |-> (out_byte == 8'h00))
    else $error("out_byte nonzero without a read");

endmodule

bind ring_buffer_keyword_scanner rbks_checker u_rbks_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_v           (out_if.valid),
  .out_rdy         (out_if.ready),
  .out_byte        (out_if.out_byte),
  .out_valid       (out_if.out_valid),
  .ring_not_empty  (out_if.ring_not_empty),
  .search_armed    (out_if.search_armed),
  .search_done     (out_if.search_done),
  .matched_keyword (out_if.matched_keyword)
);

>>> sim/ring_buffer_keyword_scanner_test.sv
// Self-checking testbench of the ring buffer keyword scanner: directed table, then random phases.
module ring_buffer_keyword_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rbks_pkg::*;

  localparam int RING_DEPTH    = 16;
  localparam int MAX_KW_CHARS  = 8;
  localparam int RANDOM_BEATS  = 1950;
  localparam int PHASE_BEATS   = 150;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_KEYWORD,
    SCAN_LINE
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       not_empty;
    logic       armed;
    logic       done;
    kw_sel_t    which;
  } scan_result_t;

  typedef struct {
    bit           is_cfg;
    cfg_idx_t     idx;
    logic [63:0]  data;
    req_t         req;
    logic [7:0]   b;
    bit           typed;
    scan_result_t res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rbks_in_if  in_ch ();
  rbks_out_if out_ch ();

  ring_buffer_keyword_scanner #(
    .RING_DEPTH       (RING_DEPTH),
    .MAX_KEYWORD_CHARS(MAX_KW_CHARS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Scanner copy: registers
  logic [63:0] kw1_chars, kw2_chars;
  logic [3:0]  kw1_len, kw2_len;
  logic [1:0]  mode_reg;
  logic        line_end_reg;
  // Scanner copy: state
  logic [7:0]  ring_mem [RING_DEPTH];
  int          wr_ptr, rd_ptr, fill_level;
  logic [3:0]  kw1_pos, kw2_pos;
  logic [1:0]  crlf_pos;
  scan_phase_t scan_phase;
  kw_sel_t     found_kw;

  scan_result_t pending_results [$];
  stim_row_t    table_rows [$];
  logic [7:0]   byte_plan [$];
  logic [7:0]   alphabet [4];

  int idle_pct, stall_pct, read_pct;
  int error_count, beats_sent, random_count, results_seen;
  int searches_done, bytes_read, overwrites, settings_used, table_beats;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run exceeded %0d cycles with %0d results outstanding", CYCLE_LIMIT,
             pending_results.size());
    $display("Verification failed");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int ring_next(input int p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int clamp_len(input logic [3:0] len);
    return (int'(len) > MAX_KW_CHARS) ? MAX_KW_CHARS : int'(len);
  endfunction

  // Naive matcher: on a mismatch restart, then retry the byte against the first character.
  function automatic bit kw_advance(input logic [63:0] chars, input logic [3:0] len_raw,
                                    input logic [3:0] pos_in, input logic [7:0] b,
                                    output logic [3:0] pos_out);
    int len;
    int pos;
    len = clamp_len(len_raw);
    pos = int'(pos_in);
    pos_out = pos_in;
    if (len == 0) return 1'b1;
    if (pos >= len) pos = 0;
    if (chars[(pos % 8) * 8 +: 8] != b) pos = 0;
    if (chars[(pos % 8) * 8 +: 8] == b) pos++;
    pos_out = 4'(pos);
    return pos >= len;
  endfunction

  function automatic bit crlf_advance(input logic [7:0] b);
    logic [7:0] wanted;
    if (crlf_pos > 2'd1) crlf_pos = 2'd0;
    wanted = (crlf_pos == 2'd0) ? CHAR_CR : CHAR_LF;
    if (wanted != b) crlf_pos = 2'd0;
    wanted = (crlf_pos == 2'd0) ? CHAR_CR : CHAR_LF;
    if (wanted == b) crlf_pos++;
    return crlf_pos >= 2'd2;
  endfunction

  function automatic void ring_push(input logic [7:0] b);
    ring_mem[wr_ptr] = b;
    wr_ptr = ring_next(wr_ptr);
    // full: drop the oldest byte
    if (fill_level >= RING_DEPTH) begin
      rd_ptr = ring_next(rd_ptr);
      overwrites++;
    end else begin
      fill_level++;
    end
  endfunction

  function automatic void scan_reset();
    kw1_chars    = '0;
    kw2_chars    = '0;
    kw1_len      = '0;
    kw2_len      = '0;
    mode_reg     = MODE_ONE;
    line_end_reg = 1'b0;
    wr_ptr       = 0;
    rd_ptr       = 0;
    fill_level   = 0;
    kw1_pos      = '0;
    kw2_pos      = '0;
    crlf_pos     = '0;
    scan_phase   = SCAN_IDLE;
    found_kw     = KW_NONE;
  endfunction

  function automatic scan_result_t scan_predict(input req_t r, input logic [7:0] b);
    scan_result_t res;
    kw_sel_t      hit;
    bit           skip;
    bit           two;
    res  = '0;
    skip = (mode_reg == MODE_SKIP);
    two  = (mode_reg >= MODE_TWO);
    case (r)
      REQ_BYTE: begin
        if (scan_phase != SCAN_IDLE) begin
          if (!skip) ring_push(b);
          if (scan_phase == SCAN_KEYWORD) begin
            hit = KW_NONE;
            if (kw_advance(kw1_chars, kw1_len, kw1_pos, b, kw1_pos)) hit = KW_FIRST;
            // second keyword is only stepped when the first did not complete
            if (hit == KW_NONE && two) begin
              if (kw_advance(kw2_chars, kw2_len, kw2_pos, b, kw2_pos)) hit = KW_SECOND;
            end
            if (hit != KW_NONE) begin
              found_kw = hit;
              if (!skip && line_end_reg) begin
                crlf_pos   = 2'd0;
                scan_phase = SCAN_LINE;
              end else begin
                scan_phase = SCAN_IDLE;
                res.done   = 1'b1;
                res.which  = hit;
              end
            end
          end else if (crlf_advance(b)) begin
            scan_phase = SCAN_IDLE;
            res.done   = 1'b1;
            res.which  = found_kw;
          end
        end
      end
      REQ_READ: begin
        if (fill_level != 0) begin
          res.rd_byte  = ring_mem[rd_ptr];
          res.rd_valid = 1'b1;
          rd_ptr       = ring_next(rd_ptr);
          fill_level--;
        end
      end
      REQ_ARM: begin
        kw1_pos    = '0;
        kw2_pos    = '0;
        crlf_pos   = '0;
        found_kw   = KW_NONE;
        scan_phase = SCAN_KEYWORD;
      end
      REQ_CLEAR: begin
        wr_ptr     = 0;
        rd_ptr     = 0;
        fill_level = 0;
      end
    endcase
    res.not_empty = (fill_level != 0);
    res.armed     = (scan_phase != SCAN_IDLE);
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] wanted);
    if (got !== wanted)
      flag_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h", results_seen, name,
                              got, wanted));
  endtask

  task automatic check_result();
    scan_result_t wanted;
    results_seen++;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      wanted = pending_results.pop_front();
      compare_field("out_byte", out_ch.out_byte, wanted.rd_byte);
      compare_field("out_valid", 8'(out_ch.out_valid), 8'(wanted.rd_valid));
      compare_field("ring_not_empty", 8'(out_ch.ring_not_empty), 8'(wanted.not_empty));
      compare_field("search_armed", 8'(out_ch.search_armed), 8'(wanted.armed));
      compare_field("search_done", 8'(out_ch.search_done), 8'(wanted.done));
      compare_field("matched_keyword", 8'(out_ch.matched_keyword), 8'(wanted.which));
    end
  endtask

  // Result side: stall at random and check every beat taken
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_result();
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_beat(input req_t r, input logic [7:0] b, input bit typed,
                           input scan_result_t typed_res);
    scan_result_t res;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= r;
    in_ch.in_byte  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = scan_predict(r, b);
    pending_results.push_back(typed ? typed_res : res);
    beats_sent++;
    if (res.done) searches_done++;
    if (res.rd_valid) bytes_read++;
  endtask

  // Hold off until every result is back, so registers change only while idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FIRST_KW:   kw1_chars    = data;
      CFG_FIRST_LEN:  kw1_len      = data[3:0];
      CFG_SECOND_KW:  kw2_chars    = data;
      CFG_SECOND_LEN: kw2_len      = data[3:0];
      CFG_MODE:       mode_reg     = data[1:0];
      CFG_LINE_END:   line_end_reg = data[0];
      default: ;
    endcase
  endtask

  function automatic void add_cfg(input cfg_idx_t idx, input logic [63:0] data);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    row.typed  = 1'b0;
    table_rows.push_back(row);
  endfunction

  function automatic void add_beat(input req_t r, input logic [7:0] b, input bit typed,
                                   input scan_result_t res);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.req    = r;
    row.b      = b;
    row.typed  = typed;
    row.res    = res;
    table_rows.push_back(row);
  endfunction

  function automatic void build_table();
    // reset settings: empty first keyword, store mode
    add_beat(REQ_READ,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, KW_NONE});
    add_beat(REQ_BYTE,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, KW_NONE});
    add_beat(REQ_CLEAR, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, KW_NONE});
    add_beat(REQ_ARM,   8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, KW_NONE});
    add_beat(REQ_BYTE,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, KW_FIRST});
    add_beat(REQ_READ,  8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, KW_NONE});
    // "ab" against "b", unused mode value, line mode
    add_cfg(CFG_FIRST_KW, 64'h6261);
    add_cfg(CFG_FIRST_LEN, 64'd2);
    add_cfg(CFG_SECOND_KW, 64'h62);
    add_cfg(CFG_SECOND_LEN, 64'd1);
    add_cfg(CFG_MODE, 64'd3);
    add_cfg(CFG_LINE_END, 64'd1);
    add_beat(REQ_ARM,   8'h00, 1'b0, '0);
    add_beat(REQ_BYTE,  8'h61, 1'b0, '0);
    add_beat(REQ_ARM,   8'h00, 1'b0, '0);
    add_beat(REQ_BYTE,  8'h62, 1'b0, '0);
    add_beat(REQ_BYTE,  CHAR_CR, 1'b0, '0);
    add_beat(REQ_CLEAR, 8'h00, 1'b0, '0);
    add_beat(REQ_BYTE,  CHAR_LF, 1'b0, '0);
    add_beat(REQ_ARM,   8'h00, 1'b0, '0);
    add_beat(REQ_BYTE,  8'h61, 1'b0, '0);
    add_beat(REQ_BYTE,  8'h62, 1'b0, '0);
    add_beat(REQ_BYTE,  CHAR_CR, 1'b0, '0);
    add_beat(REQ_BYTE,  CHAR_CR, 1'b0, '0);
    add_beat(REQ_BYTE,  CHAR_LF, 1'b0, '0);
    // skip mode: line end has no effect
    add_cfg(CFG_MODE, 64'd0);
    add_cfg(CFG_FIRST_KW, 64'hFF);
    add_cfg(CFG_FIRST_LEN, 64'd1);
    add_beat(REQ_ARM,   8'h00, 1'b0, '0);
    add_beat(REQ_BYTE,  8'h00, 1'b0, '0);
    add_beat(REQ_BYTE,  8'hFF, 1'b0, '0);
    add_beat(REQ_READ,  8'h00, 1'b0, '0);
    add_beat(REQ_CLEAR, 8'hFF, 1'b0, '0);
  endfunction

  function automatic logic [3:0] random_len();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'd8;
      2:       return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic random_settings(input int phase_no);
    logic [63:0] k1, k2;
    logic [3:0]  l1, l2;
    logic        le;
    logic [7:0]  specials [4];
    specials = '{CHAR_CR, CHAR_LF, 8'h00, 8'hFF};
    for (int i = 0; i < 4; i++)
      alphabet[i] = ($urandom_range(0, 3) == 0) ? specials[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255));
    for (int i = 0; i < 8; i++) begin
      k1[i*8 +: 8] = alphabet[$urandom_range(0, 3)];
      k2[i*8 +: 8] = alphabet[$urandom_range(0, 3)];
    end
    l1 = random_len();
    l2 = random_len();
    le = 1'($urandom_range(0, 1));
    case (phase_no % 5)
      1: begin
        k1       = '1;
        k2       = '0;
        alphabet = '{8'hFF, 8'h00, 8'hFF, CHAR_CR};
        l1       = 4'd15;
        l2       = 4'd8;
      end
      2: begin
        l1 = 4'd0;
        le = 1'b1;
      end
      default: ;
    endcase
    case (phase_no % 3)
      0:       read_pct = 5;
      1:       read_pct = 20;
      default: read_pct = 45;
    endcase
    write_reg(CFG_FIRST_KW, k1);
    write_reg(CFG_FIRST_LEN, 64'(l1));
    write_reg(CFG_SECOND_KW, k2);
    write_reg(CFG_SECOND_LEN, 64'(l2));
    write_reg(CFG_MODE, 64'(phase_no % 4));
    write_reg(CFG_LINE_END, 64'(le));
    settings_used++;
  endtask

  // Lay out the bytes of one well-formed search: junk, a keyword, junk and, mostly, CR LF
  task automatic plan_search();
    int          n;
    int          len;
    logic [63:0] chars;
    byte_plan.delete();
    n = $urandom_range(0, 5);
    repeat (n) byte_plan.push_back(alphabet[$urandom_range(0, 3)]);
    if (mode_reg >= MODE_TWO && $urandom_range(0, 1) == 1) begin
      chars = kw2_chars;
      len   = clamp_len(kw2_len);
    end else begin
      chars = kw1_chars;
      len   = clamp_len(kw1_len);
    end
    for (int i = 0; i < len; i++) byte_plan.push_back(chars[i*8 +: 8]);
    n = $urandom_range(0, 3);
    repeat (n) byte_plan.push_back(alphabet[$urandom_range(0, 3)]);
    if ($urandom_range(0, 4) != 0) begin
      byte_plan.push_back(CHAR_CR);
      byte_plan.push_back(CHAR_LF);
    end
  endtask

  task automatic random_beat();
    req_t       r;
    logic [7:0] b;
    int         roll;
    roll    = $urandom_range(0, 99);
    b       = 8'($urandom_range(0, 255));
    if (scan_phase == SCAN_IDLE) begin
      if (roll < 70) begin
        r = REQ_ARM;
        plan_search();
      end else if (roll < 80) begin
        r = REQ_BYTE;
      end else if (roll < 95) begin
        r = REQ_READ;
      end else begin
        r = REQ_CLEAR;
      end
    end else if (roll < read_pct) begin
      r = REQ_READ;
    end else if (roll < read_pct + 2) begin
      r = REQ_CLEAR;
    end else if (roll < read_pct + 4) begin
      r = REQ_ARM;
      plan_search();
    end else begin
      r = REQ_BYTE;
      // mostly follow the plan; leave one byte in ten as noise
      if (byte_plan.size() != 0 && $urandom_range(0, 9) != 0) b = byte_plan.pop_front();
      else if (byte_plan.size() == 0 && $urandom_range(0, 1) == 1)
        b = alphabet[$urandom_range(0, 3)];
    end
    random_count++;
    send_beat(r, b, 1'b0, '0);
  endtask

  initial begin
    int phase_no;
    int waited;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_BYTE;
    in_ch.in_byte  = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    read_pct       = 20;
    alphabet       = '{8'h61, 8'h62, CHAR_CR, CHAR_LF};
    scan_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_table();
    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        settle();
        write_reg(table_rows[i].idx, table_rows[i].data);
      end else begin
        send_beat(table_rows[i].req, table_rows[i].b, table_rows[i].typed, table_rows[i].res);
      end
    end
    table_beats = beats_sent;

    phase_no = 0;
    while (table_beats + random_count < RANDOM_BEATS) begin
      settle();
      case ((phase_no + phase_no / 4) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      random_settings(phase_no);
      repeat (PHASE_BEATS) random_beat();
      phase_no++;
    end

    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));

    $display("Ran %0d request beats (%0d from the table) over %0d random settings;",
             beats_sent, table_beats, settings_used);
    $display("%0d searches completed, %0d bytes read back, %0d oldest bytes overwritten.",
             searches_done, bytes_read, overwrites);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
